FILE: rtl/ols_pkg.sv
// Shared types and constants of the ordered list store.
package ols_pkg;

  // Packed widths of the stream payloads.
  localparam int IN_DATA_BITS  = 40;
  localparam int IN_USER_BITS  = 3;
  localparam int OUT_DATA_BITS = 40;
  localparam int OUT_USER_BITS = 2;
  localparam int VALUE_BITS    = 32;
  localparam int INDEX_BITS    = 4;
  localparam int COUNT_BITS    = 5;

  // List command codes carried on in_tuser.
  typedef enum logic [2:0] {
    CMD_APPEND_TAIL  = 3'd0,
    CMD_INSERT_HEAD  = 3'd1,
    CMD_REMOVE_HEAD  = 3'd2,
    CMD_REMOVE_TAIL  = 3'd3,
    CMD_REMOVE_INDEX = 3'd4,
    CMD_REMOVE_VALUE = 3'd5
  } cmd_t;

  // Result status codes carried on out_tuser.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // Position pointer updates.
  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_LEN,
    PTR_LEN_M1,
    PTR_IDX,
    PTR_INC,
    PTR_DEC
  } ptr_op_t;

  // Memory read address selection relative to the pointer.
  typedef enum logic [1:0] {
    RD_PTR,
    RD_NEXT,
    RD_PREV
  } rd_sel_t;

  // Memory write data selection.
  typedef enum logic {
    WR_VALUE,
    WR_READ
  } wr_src_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    ld_item;
    ptr_op_t ptr_op;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_src_t wr_src;
    logic    len_inc;
    logic    len_dec;
    logic    cap_removed;
    logic    res_load;
    status_t res_status;
  } dp_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] cmd;
    logic       empty;
    logic       full;
    logic       idx_bad;
    logic       ptr_zero;
    logic       ptr_last;
    logic       match;
    logic       out_busy;
  } dp_stat_t;

endpackage

FILE: rtl/ordered_list_store_top.sv
// Top level of the ordered list store.
//
// A bounded ordered list of up to DEPTH words. Each input transfer carries
// one command on in_tuser (append tail, insert head, remove head, remove
// tail, remove at index, remove first equal value) with the value and index
// on in_tdata. Each command gives exactly one output transfer: the removed
// word and the entry count on out_tdata and the status on out_tuser.
// Commands are handled one at a time; in_tready is high only while the
// controller is idle. Entries live in a single-port-write, registered-read
// memory, so each command is carried out as a sequence of memory steps.
// The result is offered in the same cycle that in_tready rises again. The
// result sits in an output register; the next command is accepted while it
// waits, but its own result is held back until out_tready takes the old one.
// Reset clears the entry count and the handshake state; the memory contents
// need no clearing, since only filled places are read.
module ordered_list_store_top #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [31:0] item_value, [35:32] item_index, [39:36] zero
  input  logic [ols_pkg::IN_DATA_BITS-1:0]  in_tdata,
  // [2:0] command
  input  logic [ols_pkg::IN_USER_BITS-1:0]  in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [31:0] removed_value, [36:32] entry_count, [39:37] zero
  output logic [ols_pkg::OUT_DATA_BITS-1:0] out_tdata,
  // [1:0] status
  output logic [ols_pkg::OUT_USER_BITS-1:0] out_tuser
);

  ols_pkg::dp_ctrl_t ctrl;
  ols_pkg::dp_stat_t stat;

  ols_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  ols_datapath #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .ctrl       (ctrl),
    .stat       (stat)
  );

endmodule

FILE: rtl/ols_datapath.sv
// Datapath of the ordered list store: entry memory, pointer, count and result register.
module ols_datapath #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [ols_pkg::IN_DATA_BITS-1:0]     in_tdata,
  input  logic [ols_pkg::IN_USER_BITS-1:0]     in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [ols_pkg::OUT_DATA_BITS-1:0]    out_tdata,
  output logic [ols_pkg::OUT_USER_BITS-1:0]    out_tuser,
  input  ols_pkg::dp_ctrl_t                    ctrl,
  output ols_pkg::dp_stat_t                    stat
);

  localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS  = $clog2(DEPTH + 1);
  localparam int VB        = ols_pkg::VALUE_BITS;
  localparam int PAD_BITS  = ols_pkg::OUT_DATA_BITS - VB - ols_pkg::COUNT_BITS;

  logic [WORD_BITS-1:0]         mem [DEPTH];
  logic [ols_pkg::IN_USER_BITS-1:0] cmd_r;
  logic [WORD_BITS-1:0]         val_r;
  logic [ols_pkg::INDEX_BITS-1:0] idx_r;
  logic [ADDR_BITS-1:0]         ptr_r;
  logic [ADDR_BITS-1:0]         ptr_nxt;
  logic [CNT_BITS-1:0]          len_r;
  logic [WORD_BITS-1:0]         rdata_r;
  logic [WORD_BITS-1:0]         removed_r;
  logic [ADDR_BITS-1:0]         rd_addr;
  logic [WORD_BITS-1:0]         wr_data;
  logic [WORD_BITS+VB-1:0]      removed_ext;
  logic                         out_valid_r;
  logic [ols_pkg::OUT_DATA_BITS-1:0] out_data_r;
  logic [ols_pkg::OUT_USER_BITS-1:0] out_user_r;

  // Capture the item fields at the input transfer.
  always_ff @(posedge clk) begin
    if (ctrl.ld_item) begin
      cmd_r <= in_tuser;
      val_r <= WORD_BITS'(in_tdata[VB-1:0]);
      idx_r <= in_tdata[VB+ols_pkg::INDEX_BITS-1:VB];
    end
  end

  // Pointer update.
  always_comb begin
    unique case (ctrl.ptr_op)
      ols_pkg::PTR_HOLD:   ptr_nxt = ptr_r;
      ols_pkg::PTR_ZERO:   ptr_nxt = '0;
      ols_pkg::PTR_LEN:    ptr_nxt = ADDR_BITS'(len_r);
      ols_pkg::PTR_LEN_M1: ptr_nxt = ADDR_BITS'(len_r - CNT_BITS'(1));
      ols_pkg::PTR_IDX:    ptr_nxt = ADDR_BITS'(idx_r);
      ols_pkg::PTR_INC:    ptr_nxt = ptr_r + ADDR_BITS'(1);
      ols_pkg::PTR_DEC:    ptr_nxt = ptr_r - ADDR_BITS'(1);
      default:             ptr_nxt = ptr_r;
    endcase
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
  end

  // Entry count; the only list state that reset clears.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (ctrl.len_inc) begin
      len_r <= len_r + CNT_BITS'(1);
    end else if (ctrl.len_dec) begin
      len_r <= len_r - CNT_BITS'(1);
    end
  end

  // Memory address and data selection.
  always_comb begin
    unique case (ctrl.rd_sel)
      ols_pkg::RD_PTR:  rd_addr = ptr_r;
      ols_pkg::RD_NEXT: rd_addr = ptr_r + ADDR_BITS'(1);
      ols_pkg::RD_PREV: rd_addr = ptr_r - ADDR_BITS'(1);
      default:          rd_addr = ptr_r;
    endcase
    wr_data = (ctrl.wr_src == ols_pkg::WR_VALUE) ? val_r : rdata_r;
  end

  // Entry memory, one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[ptr_r] <= wr_data;
    end
    if (ctrl.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Removed word, zero unless an entry is taken out.
  always_ff @(posedge clk) begin
    if (ctrl.ld_item) begin
      removed_r <= '0;
    end else if (ctrl.cap_removed) begin
      removed_r <= rdata_r;
    end
  end

  assign removed_ext = {{VB{removed_r[WORD_BITS-1]}}, removed_r};

  // Result register; a new result loads only once the old one is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.res_load) begin
      out_data_r <= {{PAD_BITS{1'b0}}, ols_pkg::COUNT_BITS'(len_r), removed_ext[VB-1:0]};
      out_user_r <= ctrl.res_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // Status toward the controller.
  always_comb begin
    stat.cmd      = cmd_r;
    stat.empty    = (len_r == '0);
    stat.full     = (len_r == CNT_BITS'(DEPTH));
    stat.idx_bad  = (32'(idx_r) >= 32'(len_r));
    stat.ptr_zero = (ptr_r == '0);
    stat.ptr_last = ((CNT_BITS'(ptr_r) + CNT_BITS'(1)) >= len_r);
    stat.match    = (rdata_r == val_r);
    stat.out_busy = out_valid_r && !out_tready;
  end

endmodule

FILE: rtl/ols_controller.sv
// Controller of the ordered list store: sequences memory steps for each command.
module ols_controller (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  ols_pkg::dp_stat_t stat,
  output ols_pkg::dp_ctrl_t ctrl
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_APP_WR,
    S_INS_CHK,
    S_INS_WR,
    S_TAKE_RD,
    S_TAKE_CAP,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_CHK,
    S_SHIFT_WR,
    S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  ols_pkg::status_t st_r, st_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_nxt        = state_r;
    st_nxt           = st_r;
    ctrl             = '0;
    ctrl.ptr_op      = ols_pkg::PTR_HOLD;
    ctrl.rd_sel      = ols_pkg::RD_PTR;
    ctrl.wr_src      = ols_pkg::WR_VALUE;
    ctrl.res_status  = st_r;
    unique case (state_r)
      S_IDLE: begin
        ctrl.ld_item = in_tvalid;
        st_nxt       = ols_pkg::ST_OK;
        if (in_tvalid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_DONE;
        unique case (stat.cmd)
          ols_pkg::CMD_APPEND_TAIL: begin
            if (stat.full) begin
              st_nxt = ols_pkg::ST_FULL;
            end else begin
              ctrl.ptr_op = ols_pkg::PTR_LEN;
              state_nxt   = S_APP_WR;
            end
          end
          ols_pkg::CMD_INSERT_HEAD: begin
            if (stat.full) begin
              st_nxt = ols_pkg::ST_FULL;
            end else begin
              ctrl.ptr_op = ols_pkg::PTR_LEN;
              state_nxt   = S_INS_CHK;
            end
          end
          ols_pkg::CMD_REMOVE_HEAD: begin
            if (stat.empty) begin
              st_nxt = ols_pkg::ST_EMPTY;
            end else begin
              ctrl.ptr_op = ols_pkg::PTR_ZERO;
              state_nxt   = S_TAKE_RD;
            end
          end
          ols_pkg::CMD_REMOVE_TAIL: begin
            if (stat.empty) begin
              st_nxt = ols_pkg::ST_EMPTY;
            end else begin
              ctrl.ptr_op = ols_pkg::PTR_LEN_M1;
              state_nxt   = S_TAKE_RD;
            end
          end
          ols_pkg::CMD_REMOVE_INDEX: begin
            if (stat.empty) begin
              st_nxt = ols_pkg::ST_EMPTY;
            end else if (stat.idx_bad) begin
              st_nxt = ols_pkg::ST_MISSING;
            end else begin
              ctrl.ptr_op = ols_pkg::PTR_IDX;
              state_nxt   = S_TAKE_RD;
            end
          end
          ols_pkg::CMD_REMOVE_VALUE: begin
            if (stat.empty) begin
              st_nxt = ols_pkg::ST_EMPTY;
            end else begin
              ctrl.ptr_op = ols_pkg::PTR_ZERO;
              state_nxt   = S_SCAN_RD;
            end
          end
          default: begin
            // Unused command codes leave the list alone.
            state_nxt = S_DONE;
          end
        endcase
      end
      S_APP_WR: begin
        ctrl.wr_en   = 1'b1;
        ctrl.len_inc = 1'b1;
        state_nxt    = S_DONE;
      end
      // Insert at the head moves entries up one place from the tail down.
      S_INS_CHK: begin
        if (stat.ptr_zero) begin
          ctrl.wr_en   = 1'b1;
          ctrl.len_inc = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          ctrl.rd_en  = 1'b1;
          ctrl.rd_sel = ols_pkg::RD_PREV;
          state_nxt   = S_INS_WR;
        end
      end
      S_INS_WR: begin
        ctrl.wr_en  = 1'b1;
        ctrl.wr_src = ols_pkg::WR_READ;
        ctrl.ptr_op = ols_pkg::PTR_DEC;
        state_nxt   = S_INS_CHK;
      end
      S_TAKE_RD: begin
        ctrl.rd_en = 1'b1;
        state_nxt  = S_TAKE_CAP;
      end
      S_TAKE_CAP: begin
        ctrl.cap_removed = 1'b1;
        state_nxt        = S_SHIFT_CHK;
      end
      // Search from the head for the first equal entry.
      S_SCAN_RD: begin
        ctrl.rd_en = 1'b1;
        state_nxt  = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (stat.match) begin
          ctrl.cap_removed = 1'b1;
          state_nxt        = S_SHIFT_CHK;
        end else if (stat.ptr_last) begin
          st_nxt    = ols_pkg::ST_MISSING;
          state_nxt = S_DONE;
        end else begin
          ctrl.ptr_op = ols_pkg::PTR_INC;
          state_nxt   = S_SCAN_RD;
        end
      end
      // Close the gap by moving later entries down one place.
      S_SHIFT_CHK: begin
        if (stat.ptr_last) begin
          ctrl.len_dec = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          ctrl.rd_en  = 1'b1;
          ctrl.rd_sel = ols_pkg::RD_NEXT;
          state_nxt   = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        ctrl.wr_en  = 1'b1;
        ctrl.wr_src = ols_pkg::WR_READ;
        ctrl.ptr_op = ols_pkg::PTR_INC;
        state_nxt   = S_SHIFT_CHK;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          ctrl.res_load = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and status registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= ols_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

endmodule

FILE: tb/ordered_list_store_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench that drives list commands and checks every result.
module ordered_list_store_top_tb;

  localparam int LIST_DEPTH    = 16;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 100;
  localparam int SINK_HOLD_LEN = 250;
  localparam int RANDOM_CHUNKS = 21;
  localparam int CHUNK_ITEMS   = 100;

  // Command codes that the block accepts but otherwise ignores.
  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  // One expected result transfer.
  typedef struct packed {
    logic [ols_pkg::VALUE_BITS-1:0] removed;
    ols_pkg::status_t               status;
    logic [ols_pkg::COUNT_BITS-1:0] count;
  } list_result_t;

  logic                              clk;
  logic                              rst_n;
  logic                              in_tvalid;
  logic                              in_tready;
  logic [ols_pkg::IN_DATA_BITS-1:0]  in_tdata;
  logic [ols_pkg::IN_USER_BITS-1:0]  in_tuser;
  logic                              out_tvalid;
  logic                              out_tready;
  logic [ols_pkg::OUT_DATA_BITS-1:0] out_tdata;
  logic [ols_pkg::OUT_USER_BITS-1:0] out_tuser;

  // Shadow copy of the list contents, head at position 0.
  logic [ols_pkg::VALUE_BITS-1:0] list_shadow[$];
  // Results predicted for accepted commands, oldest first.
  list_result_t                   pending_results[$];

  int fail_count        = 0;
  int cycle_count       = 0;
  int feed_gap_max      = 0;
  int sink_gap_max      = 0;
  int sink_hold_cycles  = 0;

  ordered_list_store_top #(
    .DEPTH    (LIST_DEPTH),
    .WORD_BITS(ols_pkg::VALUE_BITS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // 12 ns clock.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Guard against a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Apply one command to the shadow list and return the result it gives.
  function automatic list_result_t predict_list_command(
    input logic [2:0]                     cmd,
    input logic [ols_pkg::VALUE_BITS-1:0] value,
    input logic [ols_pkg::INDEX_BITS-1:0] index
  );
    list_result_t res;
    int           hit;
    res.removed = '0;
    res.status  = ols_pkg::ST_OK;
    hit         = -1;
    case (cmd)
      ols_pkg::CMD_APPEND_TAIL, ols_pkg::CMD_INSERT_HEAD: begin
        if (list_shadow.size() >= LIST_DEPTH) begin
          res.status = ols_pkg::ST_FULL;
        end else if (cmd == ols_pkg::CMD_APPEND_TAIL) begin
          list_shadow.push_back(value);
        end else begin
          list_shadow.push_front(value);
        end
      end
      ols_pkg::CMD_REMOVE_HEAD, ols_pkg::CMD_REMOVE_TAIL,
      ols_pkg::CMD_REMOVE_INDEX, ols_pkg::CMD_REMOVE_VALUE: begin
        if (list_shadow.size() == 0) begin
          res.status = ols_pkg::ST_EMPTY;
        end else begin
          case (cmd)
            ols_pkg::CMD_REMOVE_HEAD:  hit = 0;
            ols_pkg::CMD_REMOVE_TAIL:  hit = list_shadow.size() - 1;
            ols_pkg::CMD_REMOVE_INDEX: if (int'(index) < list_shadow.size()) hit = int'(index);
            default: begin
              // The match nearest the head wins.
              for (int i = 0; i < list_shadow.size(); i++) begin
                if (hit < 0 && list_shadow[i] == value) hit = i;
              end
            end
          endcase
          if (hit < 0) begin
            res.status = ols_pkg::ST_MISSING;
          end else begin
            res.removed = list_shadow[hit];
            list_shadow.delete(hit);
          end
        end
      end
      default: ;
    endcase
    res.count = ols_pkg::COUNT_BITS'(list_shadow.size());
    return res;
  endfunction

  // Offer one command and record its expected result once it is taken.
  // The valid stays high on return so that back-to-back commands need no
  // second assignment in the same step.
  task automatic send_list_command(
    input logic [2:0]                     cmd,
    input logic [ols_pkg::VALUE_BITS-1:0] value,
    input logic [ols_pkg::INDEX_BITS-1:0] index
  );
    int gap;
    gap = (feed_gap_max > 0) ? $urandom_range(0, feed_gap_max) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ols_pkg::IN_DATA_BITS'({index, value});
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_list_command(cmd, value, index));
  endtask

  // Stop offering commands until every outstanding result has arrived.
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Mostly random words, with extremes and a small pool that makes repeats.
  function automatic logic [ols_pkg::VALUE_BITS-1:0] pick_item_value();
    int roll;
    roll = $urandom_range(0, 7);
    case (roll)
      0: begin
        case ($urandom_range(0, 3))
          0:       return 32'h0000_0000;
          1:       return 32'hFFFF_FFFF;
          2:       return 32'h7FFF_FFFF;
          default: return 32'h8000_0000;
        endcase
      end
      1, 2:    return ols_pkg::VALUE_BITS'($urandom_range(0, 7));
      default: return $urandom();
    endcase
  endfunction

  // Draw one random command; fill_bias is the percentage of inserts.
  task automatic send_random_command(input int fill_bias);
    logic [2:0]                     cmd;
    logic [ols_pkg::VALUE_BITS-1:0] value;
    logic [ols_pkg::INDEX_BITS-1:0] index;
    int                             roll;
    roll  = $urandom_range(0, 99);
    value = pick_item_value();
    if (roll < 3) begin
      cmd = ($urandom_range(0, 1) != 0) ? CMD_SPARE_HI : CMD_SPARE_LO;
    end else if (roll < 3 + fill_bias) begin
      cmd = ($urandom_range(0, 1) != 0) ? ols_pkg::CMD_INSERT_HEAD : ols_pkg::CMD_APPEND_TAIL;
    end else begin
      case ($urandom_range(0, 3))
        0:       cmd = ols_pkg::CMD_REMOVE_HEAD;
        1:       cmd = ols_pkg::CMD_REMOVE_TAIL;
        2:       cmd = ols_pkg::CMD_REMOVE_INDEX;
        default: cmd = ols_pkg::CMD_REMOVE_VALUE;
      endcase
    end
    // Most searches target a word that is present; most positions are in range.
    if (cmd == ols_pkg::CMD_REMOVE_VALUE && list_shadow.size() > 0 &&
        $urandom_range(0, 3) != 0) begin
      value = list_shadow[$urandom_range(0, list_shadow.size() - 1)];
    end
    if (list_shadow.size() > 0 && $urandom_range(0, 4) != 0) begin
      index = ols_pkg::INDEX_BITS'($urandom_range(0, list_shadow.size() - 1));
    end else begin
      index = ols_pkg::INDEX_BITS'($urandom_range(0, 15));
    end
    send_list_command(cmd, value, index);
  endtask

  // Every kind of removal on an empty list, plus the ignored codes.
  task automatic test_empty_list();
    feed_gap_max = 8;
    sink_gap_max = 8;
    send_list_command(ols_pkg::CMD_REMOVE_HEAD, 32'h0000_0000, 4'd0);
    send_list_command(ols_pkg::CMD_REMOVE_TAIL, 32'hFFFF_FFFF, 4'd15);
    send_list_command(ols_pkg::CMD_REMOVE_INDEX, 32'h0000_0001, 4'd0);
    send_list_command(ols_pkg::CMD_REMOVE_VALUE, 32'h0000_0000, 4'd5);
    send_list_command(CMD_SPARE_LO, 32'hA5A5_A5A5, 4'd10);
    send_list_command(CMD_SPARE_HI, 32'h5A5A_5A5A, 4'd5);
  endtask

  // Inserts at both ends, extreme words, misses, duplicates and removals.
  task automatic test_basic_commands();
    send_list_command(ols_pkg::CMD_APPEND_TAIL, 32'h7FFF_FFFF, 4'd0);
    send_list_command(ols_pkg::CMD_INSERT_HEAD, 32'h8000_0000, 4'd15);
    send_list_command(ols_pkg::CMD_APPEND_TAIL, 32'h0000_0000, 4'd3);
    send_list_command(ols_pkg::CMD_APPEND_TAIL, 32'hFFFF_FFFF, 4'd12);
    send_list_command(ols_pkg::CMD_APPEND_TAIL, 32'h7FFF_FFFF, 4'd0);
    send_list_command(ols_pkg::CMD_REMOVE_VALUE, 32'h1234_5678, 4'd0);
    send_list_command(ols_pkg::CMD_REMOVE_INDEX, 32'h0000_0000, 4'd15);
    send_list_command(CMD_SPARE_LO, 32'hFFFF_FFFF, 4'd15);
    send_list_command(CMD_SPARE_HI, 32'h0000_0000, 4'd0);
    // The duplicate nearer the head goes first.
    send_list_command(ols_pkg::CMD_REMOVE_VALUE, 32'h7FFF_FFFF, 4'd9);
    send_list_command(ols_pkg::CMD_REMOVE_INDEX, 32'h0000_0000, 4'd1);
    send_list_command(ols_pkg::CMD_REMOVE_HEAD, 32'h0000_0000, 4'd0);
    send_list_command(ols_pkg::CMD_REMOVE_TAIL, 32'h0000_0000, 4'd0);
    send_list_command(ols_pkg::CMD_REMOVE_VALUE, 32'hFFFF_FFFF, 4'd0);
  endtask

  // Fill past capacity while the receiver holds off, so the input stalls.
  task automatic test_full_list_under_backpressure();
    wait_results_drained();
    feed_gap_max     = 0;
    sink_gap_max     = 0;
    sink_hold_cycles = SINK_HOLD_LEN;
    for (int i = 0; i < LIST_DEPTH + 2; i++) begin
      send_list_command((i % 2 != 0) ? ols_pkg::CMD_INSERT_HEAD : ols_pkg::CMD_APPEND_TAIL,
                        $urandom(), ols_pkg::INDEX_BITS'($urandom_range(0, 15)));
    end
    send_list_command(ols_pkg::CMD_REMOVE_INDEX, $urandom(), 4'd15);
    send_list_command(ols_pkg::CMD_REMOVE_VALUE, list_shadow[list_shadow.size() / 2], 4'd0);
    wait_results_drained();
  endtask

  // Long random run in chunks with varied insert bias and idling.
  task automatic test_random_traffic();
    int fill_bias;
    for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
      case ($urandom_range(0, 2))
        0:       fill_bias = 25;
        1:       fill_bias = 50;
        default: fill_bias = 75;
      endcase
      feed_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
      sink_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
      repeat (CHUNK_ITEMS) send_random_command(fill_bias);
      if (chunk % 5 == 4) wait_results_drained();
    end
  endtask

  // Result receiver: random stalls, and one long hold when requested.
  initial begin : result_sink
    int stall;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (sink_hold_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (sink_hold_cycles) @(posedge clk);
        sink_hold_cycles = 0;
      end
      stall = (sink_gap_max > 0) ? $urandom_range(0, sink_gap_max) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Compare each result transfer with the oldest prediction.
  always @(posedge clk) begin : result_check
    list_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected: data %h, user %h", out_tdata, out_tuser);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[ols_pkg::VALUE_BITS-1:0] !== want.removed) begin
          $error("removed_value: expected %h, got %h", want.removed,
                 out_tdata[ols_pkg::VALUE_BITS-1:0]);
          fail_count++;
        end
        if (out_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tuser);
          fail_count++;
        end
        if (out_tdata[ols_pkg::VALUE_BITS +: ols_pkg::COUNT_BITS] !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count,
                 out_tdata[ols_pkg::VALUE_BITS +: ols_pkg::COUNT_BITS]);
          fail_count++;
        end
      end
    end
  end

  // Reset, then run the tests in turn.
  initial begin
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    rst_n     <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_basic_commands();
    test_full_list_under_backpressure();
    test_random_traffic();
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
